FILE: rtl/psc_pkg.sv
// Shared constants and types for the plane and sphere contact pipeline.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

   localparam int FIELD_W = 60;   // packed triple port width
   localparam int ROT_W   = 20;   // Q1.18 rotation entry
   localparam int RAD_W   = 19;   // unsigned Q9.10 length
   localparam int NORM_W  = 20;   // Q1.18 normal component
   localparam int A_W     = 28;   // offset magnitude in Q.18 once inside the radius
   localparam int SQ_W    = 58;   // sum of three squared magnitudes
   localparam int ROOT_W  = 29;   // integer square root of SQ_W bits
   localparam int Q_W     = 19;   // quotient bits, at most one in Q1.18
   localparam int SH_W    = 5;    // normalizing shift amount
   localparam int CSR_W   = 3;

   localparam logic [NORM_W-1:0] Q_ONE = NORM_W'(262144);

   localparam logic [CSR_W-1:0] CSR_PLANE_ROT_ROW0    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_PLANE_ROT_ROW1    = 3'd1;
   localparam logic [CSR_W-1:0] CSR_PLANE_ROT_ROW2    = 3'd2;
   localparam logic [CSR_W-1:0] CSR_PLANE_ORIGIN      = 3'd3;
   localparam logic [CSR_W-1:0] CSR_PLANE_HALF_WIDTH  = 3'd4;
   localparam logic [CSR_W-1:0] CSR_PLANE_HALF_LENGTH = 3'd5;
   localparam logic [CSR_W-1:0] CSR_PLANE_SKIN        = 3'd6;

   typedef struct packed {
      logic       hit;
      logic       up;
      logic [2:0] neg;
   } psc_flags_type;

   typedef logic [2:0][A_W-1:0] mag3_type;

endpackage
`default_nettype wire

FILE: rtl/psc_transform.sv
// Four-stage transform of the sphere center into the plane frame.
`timescale 1ns / 1ps
`default_nettype none
module psc_transform #(
   parameter int CW = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [psc_pkg::FIELD_W-1:0]   sph_row0,
   input  logic [psc_pkg::FIELD_W-1:0]   sph_row1,
   input  logic [psc_pkg::FIELD_W-1:0]   sph_row2,
   input  logic [psc_pkg::FIELD_W-1:0]   sph_pos,
   input  logic [psc_pkg::FIELD_W-1:0]   sph_cen,
   input  logic [psc_pkg::RAD_W-1:0]     sph_radius,
   input  logic [psc_pkg::FIELD_W-1:0]   pln_row0,
   input  logic [psc_pkg::FIELD_W-1:0]   pln_row1,
   input  logic [psc_pkg::FIELD_W-1:0]   pln_row2,
   input  logic [psc_pkg::FIELD_W-1:0]   pln_origin,
   input  logic [psc_pkg::RAD_W-1:0]     pln_skin,
   output logic                          out_valid,
   output logic signed [CW+14:0]         loc_out [3],
   output logic [psc_pkg::RAD_W:0]       rsum_out
);
   import psc_pkg::*;

   localparam int PACK_W = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;
   localparam int P1_W   = ROT_W + CW;
   localparam int ACC1_W = CW + 22;
   localparam int D_W    = CW + 12;
   localparam int P2_W   = ROT_W + D_W;
   localparam int ACC2_W = CW + 33;
   localparam int LOC_W  = CW + 15;
   localparam logic signed [ACC1_W-1:0] HALF1 = ACC1_W'(512);
   localparam logic signed [ACC2_W-1:0] HALF2 = ACC2_W'(131072);

   logic [PACK_W-1:0]   pos_p, cen_p, org_p;
   logic [FIELD_W-1:0]  srow [3];
   logic [FIELD_W-1:0]  prow [3];

   logic signed [CW:0]        diff1_in [3];
   logic signed [CW:0]        diff1_ff [3];
   logic signed [P1_W-1:0]    prod1_in [3][3];
   logic signed [P1_W-1:0]    prod1_ff [3][3];
   logic signed [D_W-1:0]     d2_in [3];
   logic signed [D_W-1:0]     d2_ff [3];
   logic signed [P2_W-1:0]    prod3_in [3][3];
   logic signed [P2_W-1:0]    prod3_ff [3][3];
   logic signed [LOC_W-1:0]   loc4_in [3];
   logic signed [LOC_W-1:0]   loc4_ff [3];
   logic [RAD_W:0]            rsum1_ff, rsum2_ff, rsum3_ff, rsum4_ff;
   logic                      vld1_ff, vld2_ff, vld3_ff, vld4_ff;

   assign pos_p = PACK_W'(sph_pos);
   assign cen_p = PACK_W'(sph_cen);
   assign org_p = PACK_W'(pln_origin);
   assign srow[0] = sph_row0;
   assign srow[1] = sph_row1;
   assign srow[2] = sph_row2;
   assign prow[0] = pln_row0;
   assign prow[1] = pln_row1;
   assign prow[2] = pln_row2;

   // Stage 1: sphere rotation products and the position offset.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         diff1_in[r] = (CW+1)'($signed(pos_p[r*CW +: CW]))
                     - (CW+1)'($signed(org_p[r*CW +: CW]));
         for (int c = 0; c < 3; c++) begin
            prod1_in[r][c] = $signed(srow[r][c*ROT_W +: ROT_W])
                           * $signed(cen_p[c*CW +: CW]);
         end
      end
   end

   // Stage 2: world offset rounded from Q.28 to Q.18.
   always_comb begin
      logic signed [ACC1_W-1:0] acc;
      for (int r = 0; r < 3; r++) begin
         acc = (ACC1_W'(diff1_ff[r]) <<< 18) + ACC1_W'(prod1_ff[r][0])
             + ACC1_W'(prod1_ff[r][1]) + ACC1_W'(prod1_ff[r][2]) + HALF1;
         d2_in[r] = D_W'(acc >>> 10);
      end
   end

   // Stage 3: products with the transposed plane rotation.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            prod3_in[c][r] = $signed(prow[r][c*ROT_W +: ROT_W]) * d2_ff[r];
         end
      end
   end

   // Stage 4: local coordinates rounded from Q.36 to Q.18.
   always_comb begin
      logic signed [ACC2_W-1:0] acc;
      for (int c = 0; c < 3; c++) begin
         acc = ACC2_W'(prod3_ff[c][0]) + ACC2_W'(prod3_ff[c][1])
             + ACC2_W'(prod3_ff[c][2]) + HALF2;
         loc4_in[c] = LOC_W'(acc >>> 18);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff1_ff <= diff1_in;
         prod1_ff <= prod1_in;
         d2_ff    <= d2_in;
         prod3_ff <= prod3_in;
         loc4_ff  <= loc4_in;
         rsum1_ff <= (RAD_W+1)'(sph_radius) + (RAD_W+1)'(pln_skin);
         rsum2_ff <= rsum1_ff;
         rsum3_ff <= rsum2_ff;
         rsum4_ff <= rsum3_ff;
      end
   end

   assign out_valid = vld4_ff;
   assign loc_out   = loc4_ff;
   assign rsum_out  = rsum4_ff;

endmodule
`default_nettype wire

FILE: rtl/psc_test.sv
// Clamp to the rectangle, radius test and normalizing shift, four stages.
`timescale 1ns / 1ps
`default_nettype none
module psc_test #(
   parameter int CW = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic signed [CW+14:0]        loc_in [3],
   input  logic [psc_pkg::RAD_W:0]      rsum_in,
   input  logic [psc_pkg::RAD_W-1:0]    half_width,
   input  logic [psc_pkg::RAD_W-1:0]    half_length,
   output logic                         out_valid,
   output psc_pkg::psc_flags_type       flags_out,
   output psc_pkg::mag3_type            mag_out,
   output logic [psc_pkg::SQ_W-1:0]     sumsq_out
);
   import psc_pkg::*;

   localparam int LOC_W = CW + 15;
   localparam int N_W   = LOC_W + 1;

   logic signed [LOC_W-1:0] lim [2];
   logic signed [LOC_W-1:0] clp [2];
   logic signed [N_W-1:0]   n5 [3];
   logic [N_W-1:0]          m5 [3];
   logic [A_W-1:0]          rad5_in;
   logic                    over5_in;

   logic                    vld5_ff, vld6_ff, vld7_ff, vld8_ff;
   mag3_type                a5_ff, a6_ff, a7_ff, a8_ff;
   logic [2:0]              neg5_ff, neg6_ff;
   logic                    up5_ff, up6_ff, over5_ff, over6_ff;
   logic [A_W-1:0]          rad5_ff;
   logic [2*A_W-1:0]        sq6_ff [3];
   logic [2*A_W-1:0]        radsq6_ff;
   logic [SQ_W-1:0]         sum7_in, sum7_ff, sum8_ff;
   logic [A_W-1:0]          mx7;
   logic [SH_W-1:0]         sh7_in, sh7_ff;
   psc_flags_type           flg7_ff, flg8_ff;

   // Stage 5: closest point on the rectangle and the offset magnitudes.
   assign lim[0]  = LOC_W'($signed({1'b0, half_width, 8'b0}));
   assign lim[1]  = LOC_W'($signed({1'b0, half_length, 8'b0}));
   assign rad5_in = {rsum_in, 8'b0};

   always_comb begin
      over5_in = 1'b0;
      for (int c = 0; c < 2; c++) begin
         if (loc_in[c] > lim[c]) begin
            clp[c] = lim[c];
         end else if (loc_in[c] < -lim[c]) begin
            clp[c] = -lim[c];
         end else begin
            clp[c] = loc_in[c];
         end
         n5[c] = N_W'(loc_in[c]) - N_W'(clp[c]);
      end
      n5[2] = N_W'(loc_in[2]);
      for (int c = 0; c < 3; c++) begin
         m5[c] = n5[c][N_W-1] ? -n5[c] : n5[c];
         if (m5[c] > N_W'(rad5_in)) begin
            over5_in = 1'b1;
         end
      end
   end

   // Stage 7: squared-length compare and the left shift that brings the
   // largest magnitude to bit 27.
   always_comb begin
      sum7_in = SQ_W'(sq6_ff[0]) + SQ_W'(sq6_ff[1]) + SQ_W'(sq6_ff[2]);
      mx7 = a6_ff[0];
      if (a6_ff[1] > mx7) begin
         mx7 = a6_ff[1];
      end
      if (a6_ff[2] > mx7) begin
         mx7 = a6_ff[2];
      end
      sh7_in = '0;
      for (int i = 0; i < A_W; i++) begin
         if (mx7[i]) begin
            sh7_in = SH_W'(A_W - 1 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else if (adv) begin
         vld5_ff <= in_valid;
         vld6_ff <= vld5_ff;
         vld7_ff <= vld6_ff;
         vld8_ff <= vld7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            a5_ff[c]   <= A_W'(m5[c]);
            neg5_ff[c] <= n5[c][N_W-1];
            sq6_ff[c]  <= (2*A_W)'(a5_ff[c]) * (2*A_W)'(a5_ff[c]);
            a8_ff[c]   <= A_W'(a7_ff[c] << sh7_ff);
         end
         up5_ff    <= loc_in[2][LOC_W-1] || (loc_in[2] == '0);
         over5_ff  <= over5_in;
         rad5_ff   <= rad5_in;
         a6_ff     <= a5_ff;
         neg6_ff   <= neg5_ff;
         up6_ff    <= up5_ff;
         over6_ff  <= over5_ff;
         radsq6_ff <= (2*A_W)'(rad5_ff) * (2*A_W)'(rad5_ff);
         a7_ff     <= a6_ff;
         sum7_ff   <= sum7_in;
         sh7_ff    <= sh7_in;
         flg7_ff.hit <= !over6_ff && (sum7_in <= SQ_W'(radsq6_ff));
         flg7_ff.up  <= up6_ff;
         flg7_ff.neg <= neg6_ff;
         sum8_ff   <= sum7_ff << {sh7_ff, 1'b0};
         flg8_ff   <= flg7_ff;
      end
   end

   assign out_valid = vld8_ff;
   assign flags_out = flg8_ff;
   assign mag_out   = a8_ff;
   assign sumsq_out = sum8_ff;

endmodule
`default_nettype wire

FILE: rtl/psc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psc_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [psc_pkg::SQ_W-1:0]    radicand,
   input  psc_pkg::psc_flags_type      flags_in,
   input  psc_pkg::mag3_type           mag_in,
   output logic                        out_valid,
   output logic [psc_pkg::ROOT_W-1:0]  root_out,
   output psc_pkg::psc_flags_type      flags_out,
   output psc_pkg::mag3_type           mag_out
);
   import psc_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic                vld_ff  [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [SQ_W-1:0]     rad_ff  [ROOT_W];
   psc_flags_type       flg_ff  [ROOT_W];
   mag3_type            mag_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              vld_src;
      logic [REM_W-1:0]  rem_src, remx, trial;
      logic [ROOT_W-1:0] root_src;
      logic [SQ_W-1:0]   rad_src;
      psc_flags_type     flg_src;
      mag3_type          mag_src;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
         assign flg_src  = flags_in;
         assign mag_src  = mag_in;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign flg_src  = flg_ff[k-1];
         assign mag_src  = mag_ff[k-1];
      end

      // Bring down the next two radicand bits and try a one in the root.
      assign remx  = {rem_src[REM_W-3:0], rad_src[SQ_W-1 -: 2]};
      assign trial = {root_src, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (remx >= trial) begin
               rem_ff[k]  <= remx - trial;
               root_ff[k] <= {root_src[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= remx;
               root_ff[k] <= {root_src[ROOT_W-2:0], 1'b0};
            end
            rad_ff[k] <= rad_src << 2;
            flg_ff[k] <= flg_src;
            mag_ff[k] <= mag_src;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign root_out  = root_ff[ROOT_W-1];
   assign flags_out = flg_ff[ROOT_W-1];
   assign mag_out   = mag_ff[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/psc_div.sv
// Three-lane pipelined restoring divider for the normal components.
`timescale 1ns / 1ps
`default_nettype none
module psc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [psc_pkg::ROOT_W-1:0]  len_in,
   input  psc_pkg::psc_flags_type      flags_in,
   input  psc_pkg::mag3_type           mag_in,
   output logic                        out_valid,
   output psc_pkg::psc_flags_type      flags_out,
   output logic [2:0][psc_pkg::Q_W-1:0] quot_out
);
   import psc_pkg::*;

   localparam int NUM_W = A_W + 18 + 1;
   localparam int REM_W = ROOT_W + 1;

   logic [NUM_W-1:0]            num [3];
   logic                        vld_ff  [Q_W];
   logic [2:0][REM_W-1:0]       rem_ff  [Q_W];
   logic [2:0][Q_W-1:0]         low_ff  [Q_W];
   logic [2:0][Q_W-1:0]         quo_ff  [Q_W];
   logic [ROOT_W-1:0]           len_ff  [Q_W];
   psc_flags_type               flg_ff  [Q_W];

   // Numerator is |n| * 2^18 + len/2; the quotient stays below 2^19, so the
   // partial remainder starts from its upper bits.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num[c] = {1'b0, mag_in[c], 18'b0} + NUM_W'(len_in >> 1);
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic                  vld_src;
      logic [2:0][REM_W-1:0] rem_src;
      logic [2:0][Q_W-1:0]   low_src, quo_src;
      logic [ROOT_W-1:0]     len_src;
      psc_flags_type         flg_src;

      if (k == 0) begin : g_first
         always_comb begin
            for (int c = 0; c < 3; c++) begin
               rem_src[c] = REM_W'(num[c] >> Q_W);
               low_src[c] = num[c][Q_W-1:0];
            end
         end
         assign vld_src = in_valid;
         assign quo_src = '0;
         assign len_src = len_in;
         assign flg_src = flags_in;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign len_src = len_ff[k-1];
         assign flg_src = flg_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         logic [REM_W-1:0] remx;
         if (adv) begin
            for (int c = 0; c < 3; c++) begin
               remx = {rem_src[c][REM_W-2:0], low_src[c][Q_W-1]};
               if (remx >= REM_W'(len_src)) begin
                  rem_ff[k][c] <= remx - REM_W'(len_src);
                  quo_ff[k][c] <= {quo_src[c][Q_W-2:0], 1'b1};
               end else begin
                  rem_ff[k][c] <= remx;
                  quo_ff[k][c] <= {quo_src[c][Q_W-2:0], 1'b0};
               end
               low_ff[k][c] <= low_src[c] << 1;
            end
            len_ff[k] <= len_src;
            flg_ff[k] <= flg_src;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign flags_out = flg_ff[Q_W-1];
   assign quot_out  = quo_ff[Q_W-1];

endmodule
`default_nettype wire

FILE: rtl/plane_sphere_contact.sv
// Top level of the sphere against bounded plane contact pipeline.
//
//   channel  direction  handshake             contents
//   req      in         req_valid/req_stall   sphere pose, centroid, radius
//   rsp      out        rsp_valid/rsp_stall   hit flag and plane-frame normal
//   csr      in         csr_we                plane pose, extents and skin
//
// One item enters per cycle unless req_stall is high; each result passes the
// transform, the test, the 29-stage square root and the 19-stage divider.
// The whole pipeline moves together and freezes while a held result is stalled.
// Reset is synchronous and clears the valid bits and the plane registers.
`timescale 1ns / 1ps
`default_nettype none
module plane_sphere_contact #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [psc_pkg::FIELD_W-1:0]        req_sphere_rot_row0,
   input  logic [psc_pkg::FIELD_W-1:0]        req_sphere_rot_row1,
   input  logic [psc_pkg::FIELD_W-1:0]        req_sphere_rot_row2,
   input  logic [psc_pkg::FIELD_W-1:0]        req_sphere_position,
   input  logic [psc_pkg::FIELD_W-1:0]        req_sphere_centroid,
   input  logic [psc_pkg::RAD_W-1:0]          req_sphere_radius,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_contact_hit,
   output logic signed [psc_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [psc_pkg::NORM_W-1:0]  rsp_normal_y,
   output logic signed [psc_pkg::NORM_W-1:0]  rsp_normal_z,
   input  logic                               csr_we,
   input  logic [psc_pkg::CSR_W-1:0]          csr_index,
   input  logic [psc_pkg::FIELD_W-1:0]        csr_wdata
);
   import psc_pkg::*;

   localparam int LOC_W = COORD_WIDTH + 15;

   logic [FIELD_W-1:0] plane_rot_row0_ff, plane_rot_row1_ff, plane_rot_row2_ff;
   logic [FIELD_W-1:0] plane_origin_ff;
   logic [RAD_W-1:0]   plane_half_width_ff, plane_half_length_ff, plane_skin_ff;

   logic                    adv;
   logic                    xf_valid, ts_valid, sq_valid, dv_valid;
   logic signed [LOC_W-1:0] xf_loc [3];
   logic [RAD_W:0]          xf_rsum;
   psc_flags_type           ts_flags, sq_flags, dv_flags;
   mag3_type                ts_mag, sq_mag;
   logic [SQ_W-1:0]         ts_sumsq;
   logic [ROOT_W-1:0]       sq_root;
   logic [2:0][Q_W-1:0]     dv_quot;
   logic [NORM_W-1:0]       comp [3];

   logic                    rsp_valid_ff;
   logic                    hit_ff;
   logic [NORM_W-1:0]       nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_rot_row0_ff    <= '0;
         plane_rot_row1_ff    <= '0;
         plane_rot_row2_ff    <= '0;
         plane_origin_ff      <= '0;
         plane_half_width_ff  <= '0;
         plane_half_length_ff <= '0;
         plane_skin_ff        <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLANE_ROT_ROW0:    plane_rot_row0_ff    <= csr_wdata;
            CSR_PLANE_ROT_ROW1:    plane_rot_row1_ff    <= csr_wdata;
            CSR_PLANE_ROT_ROW2:    plane_rot_row2_ff    <= csr_wdata;
            CSR_PLANE_ORIGIN:      plane_origin_ff      <= csr_wdata;
            CSR_PLANE_HALF_WIDTH:  plane_half_width_ff  <= csr_wdata[RAD_W-1:0];
            CSR_PLANE_HALF_LENGTH: plane_half_length_ff <= csr_wdata[RAD_W-1:0];
            CSR_PLANE_SKIN:        plane_skin_ff        <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline advances unless a finished result is waiting on a stall.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   psc_transform #(.CW(COORD_WIDTH)) u_transform (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .sph_row0   (req_sphere_rot_row0),
      .sph_row1   (req_sphere_rot_row1),
      .sph_row2   (req_sphere_rot_row2),
      .sph_pos    (req_sphere_position),
      .sph_cen    (req_sphere_centroid),
      .sph_radius (req_sphere_radius),
      .pln_row0   (plane_rot_row0_ff),
      .pln_row1   (plane_rot_row1_ff),
      .pln_row2   (plane_rot_row2_ff),
      .pln_origin (plane_origin_ff),
      .pln_skin   (plane_skin_ff),
      .out_valid  (xf_valid),
      .loc_out    (xf_loc),
      .rsum_out   (xf_rsum)
   );

   psc_test #(.CW(COORD_WIDTH)) u_test (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (xf_valid),
      .loc_in      (xf_loc),
      .rsum_in     (xf_rsum),
      .half_width  (plane_half_width_ff),
      .half_length (plane_half_length_ff),
      .out_valid   (ts_valid),
      .flags_out   (ts_flags),
      .mag_out     (ts_mag),
      .sumsq_out   (ts_sumsq)
   );

   psc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (ts_valid),
      .radicand  (ts_sumsq),
      .flags_in  (ts_flags),
      .mag_in    (ts_mag),
      .out_valid (sq_valid),
      .root_out  (sq_root),
      .flags_out (sq_flags),
      .mag_out   (sq_mag)
   );

   psc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .len_in    (sq_root),
      .flags_in  (sq_flags),
      .mag_in    (sq_mag),
      .out_valid (dv_valid),
      .flags_out (dv_flags),
      .quot_out  (dv_quot)
   );

   always_comb begin
      logic [NORM_W-1:0] qc;
      for (int c = 0; c < 3; c++) begin
         qc = NORM_W'(dv_quot[c]);
         if (qc > Q_ONE) begin
            qc = Q_ONE;
         end
         comp[c] = dv_flags.neg[c] ? -qc : qc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= dv_flags.hit;
         if (!dv_flags.hit) begin
            nx_ff <= '0;
            ny_ff <= '0;
            nz_ff <= '0;
         end else if (dv_flags.up) begin
            nx_ff <= '0;
            ny_ff <= '0;
            nz_ff <= Q_ONE;
         end else begin
            nx_ff <= comp[0];
            ny_ff <= comp[1];
            nz_ff <= comp[2];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_contact_hit = hit_ff;
   assign rsp_normal_x    = nx_ff;
   assign rsp_normal_y    = ny_ff;
   assign rsp_normal_z    = nz_ff;

`ifndef NO_ASSERTIONS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_contact_hit |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("miss result carries a nonzero normal");

   a_hit_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contact_hit |-> !rsp_normal_z[NORM_W-1])
      else $error("contact normal points below the plane");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= $signed(Q_ONE) && rsp_normal_x >= -$signed(Q_ONE)
         && rsp_normal_z <= $signed(Q_ONE))
      else $error("normal component out of range");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");
`endif

endmodule
`default_nettype wire
